[rtl/bdascii_pkg.sv]
`default_nettype none
package bdascii_pkg;
  localparam int unsigned CharZero = 48;
  localparam int unsigned DigitW = 4;
  localparam int unsigned CharW = 6;

  // BCD-correct one nibble (add 3 when >= 5) before the shift
  function automatic logic [DigitW-1:0] dabble(input logic [DigitW-1:0] d);
    dabble = (d >= 4'd5) ? d + 4'd3 : d;
  endfunction
endpackage
`default_nettype wire

[rtl/bdascii_conv.sv]
`default_nettype none
// Pipelined double dabble: one stage per input bit, each stage one
// correct-and-shift over all digits. A stall holds every occupied stage; empty stages still fill.
module bdascii_conv #(
  parameter int unsigned ValueBits = 64,
  parameter int unsigned NumDigits = 20
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [ValueBits-1:0]          in_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [NumDigits*4-1:0]             out_bcd_o
);
  import bdascii_pkg::*;

  logic [ValueBits-1:0]   val_q [ValueBits];
  logic [NumDigits*4-1:0] bcd_q [ValueBits];
  logic [ValueBits-1:0]   vld_q;
  logic [ValueBits-1:0]   adv;

  // stage s moves when its slot is empty or downstream moves
  always_comb begin
    adv[ValueBits-1] = !vld_q[ValueBits-1] || out_ready_i;
    for (int s = ValueBits - 2; s >= 0; s--) begin
      adv[s] = !vld_q[s] || adv[s+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[ValueBits-1];
  assign out_bcd_o   = bcd_q[ValueBits-1];

  function automatic logic [NumDigits*4-1:0] step(input logic [NumDigits*4-1:0] b,
                                                  input logic bit_in);
    logic [NumDigits*4-1:0] c;
    for (int k = 0; k < NumDigits; k++) begin
      c[k*4 +: 4] = dabble(b[k*4 +: 4]);
    end
    step = {c[NumDigits*4-2:0], bit_in};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int s = 1; s < ValueBits; s++) begin
        if (adv[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      val_q[0] <= {in_value_i[ValueBits-2:0], 1'b0};
      bcd_q[0] <= {{(NumDigits*4-1){1'b0}}, in_value_i[ValueBits-1]};
    end
    for (int s = 1; s < ValueBits; s++) begin
      if (adv[s]) begin
        val_q[s] <= {val_q[s-1][ValueBits-2:0], 1'b0};
        bcd_q[s] <= step(bcd_q[s-1], val_q[s-1][ValueBits-1]);
      end
    end
  end

  a_outhold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("out dropped");
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0]) else $error("beat lost");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[0] |-> in_ready_o) else $error("ready low on empty stage");
endmodule
`default_nettype wire

[rtl/bdascii_emit.sv]
`default_nettype none
// Serializes one BCD word into characters, leading zeros skipped.
module bdascii_emit #(
  parameter int unsigned NumDigits = 20
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [NumDigits*4-1:0]    in_bcd_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [5:0]                     out_char_code_o,
  output logic                           out_last_char_o
);
  import bdascii_pkg::*;
  localparam int unsigned IdxW = $clog2(NumDigits);

  logic [NumDigits*4-1:0] bcd_q;
  logic [IdxW-1:0]        idx_q, idx_d, top;
  logic                   busy_q;
  logic [3:0]             dig;

  // highest nonzero digit, digit zero at least
  always_comb begin
    top = '0;
    for (int k = 1; k < NumDigits; k++) begin
      if (in_bcd_i[k*4 +: 4] != 4'd0) top = IdxW'(k);
    end
  end

  assign dig             = bcd_q[idx_q*4 +: 4];
  assign out_valid_o     = busy_q;
  assign out_char_code_o = CharW'(CharZero) + {2'b00, dig};
  assign out_last_char_o = (idx_q == '0);
  assign in_ready_o      = !busy_q || (out_ready_i && out_last_char_o);
  assign idx_d           = idx_q - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (in_valid_i && in_ready_o) begin
      busy_q <= 1'b1;
      idx_q  <= top;
    end else if (busy_q && out_ready_i) begin
      if (out_last_char_o) busy_q <= 1'b0;
      else idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) bcd_q <= in_bcd_i;
  end

  a_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> dig <= 4'd9) else $error("bad digit");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(idx_q)) else $error("slip");
  a_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) && idx_q != '0 |-> dig != 4'd0) else $error("leading zero");
endmodule
`default_nettype wire

[rtl/binary_to_decimal_ascii.sv]
`default_nettype none
// Unsigned binary to decimal ASCII text.
// Input channel: value_i, one beat per number (low VALUE_BITS bits used).
// Output channel: one beat per character '0'..'9', most significant digit
// first, no leading zeros; last_char_o marks the final digit. Zero gives "0".
// Structure: VALUE_BITS pipeline stages of double dabble (one bit per stage),
// then a registered character serializer.
// Throughput: the converter pipeline takes a new value every cycle unless it is
// full and stalled; the character serializer sends one character per cycle while
// char_ready_i is high, and a number gives as many characters as it has digits (1 to 20).
// Reset empties all stages. When the receiver stalls, occupied stages hold and
// backpressure reaches value_ready_o once the stages fill; nothing is lost or repeated.
module binary_to_decimal_ascii #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        value_valid_i,
  output logic             value_ready_o,
  input  wire logic [63:0] value_i,
  output logic             char_valid_o,
  input  wire logic        char_ready_i,
  output logic [5:0]       char_code_o,
  output logic             last_char_o
);
  import bdascii_pkg::*;
  localparam int unsigned NumDigits = (VALUE_BITS * 30103 + 99999) / 100000 + 1;

  logic                   mid_valid, mid_ready;
  logic [NumDigits*4-1:0] mid_bcd;

  bdascii_conv #(.ValueBits(VALUE_BITS), .NumDigits(NumDigits)) u_conv (
    .clk_i, .rst_ni,
    .in_valid_i(value_valid_i), .in_ready_o(value_ready_o),
    .in_value_i(value_i[VALUE_BITS-1:0]),
    .out_valid_o(mid_valid), .out_ready_i(mid_ready), .out_bcd_o(mid_bcd)
  );

  bdascii_emit #(.NumDigits(NumDigits)) u_emit (
    .clk_i, .rst_ni,
    .in_valid_i(mid_valid), .in_ready_o(mid_ready), .in_bcd_i(mid_bcd),
    .out_valid_o(char_valid_o), .out_ready_i(char_ready_i),
    .out_char_code_o(char_code_o), .out_last_char_o(last_char_o)
  );

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o |-> char_code_o >= 6'(CharZero)) else $error("bad char");
  a_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_valid && !mid_ready |=> mid_valid) else $error("mid drop");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o && !char_ready_i |=> $stable(last_char_o)) else $error("last moved");
endmodule
`default_nettype wire

[test/binary_to_decimal_ascii_tb.sv]
`timescale 1ns / 1ps
module binary_to_decimal_ascii_tb;
  localparam int unsigned ValueBits = 64;
  localparam int unsigned MaxCycles = 400000;
  localparam int unsigned DrainCycles = ValueBits + 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        value_valid_i = 1'b0;
  logic        value_ready_o;
  logic [63:0] value_i = '0;
  logic        char_valid_o;
  logic        char_ready_i = 1'b0;
  logic [5:0]  char_code_o;
  logic        last_char_o;

  typedef struct packed {
    logic [5:0] code;
    logic       last;
  } char_t;

  char_t       expected_chars[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          recv_hold = 1'b0;

  binary_to_decimal_ascii #(.VALUE_BITS(ValueBits)) i_dut (
    .clk_i, .rst_ni, .value_valid_i, .value_ready_o, .value_i,
    .char_valid_o, .char_ready_i, .char_code_o, .last_char_o
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("binary_to_decimal_ascii regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Decimal text of the masked value, most significant digit first.
  task automatic predict_digits(input logic [63:0] val);
    logic [63:0] v;
    logic [3:0]  digs[20];
    int          n;
    char_t       c;
    v = (ValueBits >= 64) ? val : (val & ((64'd1 << ValueBits) - 1));
    n = 0;
    do begin
      digs[n] = 4'(v % 64'd10);
      v = v / 64'd10;
      n++;
    end while (v != 0 && n < 20);
    for (int k = n - 1; k >= 0; k--) begin
      c.code = 6'(48 + digs[k]);
      c.last = (k == 0);
      expected_chars.push_back(c);
    end
  endtask

  // Valid stays up between back-to-back beats; it drops only on idle cycles.
  task automatic send_value(input logic [63:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      value_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    value_valid_i <= 1'b1;
    value_i <= val;
    predict_digits(val);
    do @(posedge clk_i); while (!value_ready_o);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && char_valid_o && char_ready_i) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %0d", char_code_o));
      end else begin
        char_t e;
        e = expected_chars.pop_front();
        if (char_code_o !== e.code)
          report_mismatch($sformatf("char_code %0d exp %0d", char_code_o, e.code));
        if (last_char_o !== e.last)
          report_mismatch($sformatf("last_char %0b exp %0b", last_char_o, e.last));
      end
    end
  end

  always @(posedge clk_i) begin
    char_ready_i <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    // mostly varied magnitudes so every digit count shows up
    if ($urandom_range(3) != 0) v = v >> $urandom_range(63);
    return v;
  endfunction

  task automatic test_directed();
    logic [63:0] p;
    send_value(64'd0);
    send_value(64'd9);
    send_value(64'd10);
    send_value('1);
    send_value(64'h8000_0000_0000_0000);
    send_value(64'h5555_5555_5555_5555);
    send_value(64'hAAAA_AAAA_AAAA_AAAA);
    send_value(64'd10000000000000000000);
    send_value(64'd9999999999999999999);
    p = 64'd1;
    for (int i = 0; i < 15; i++) begin
      send_value(p - 1);
      p = p * 64'd20;
    end
  endtask

  task automatic test_random(input int unsigned n, input int unsigned s_pct,
                             input int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n) send_value(rand_value());
  endtask

  // Receiver stops for a long stretch while values keep coming; more values
  // than the pipeline holds, so the input stalls.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      repeat (100) send_value(rand_value());
    join
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 20;
    recv_idle_pct = 10;
    test_directed();
    test_random(60, 20, 80);
    test_random(60, 80, 20);
    test_random(60, 0, 0);
    test_backpressure();
    value_valid_i <= 1'b0;
    recv_idle_pct = 0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("binary_to_decimal_ascii regression: pass");
    end else begin
      $display("binary_to_decimal_ascii regression: fail");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/bdascii_pkg.sv
rtl/bdascii_conv.sv
rtl/bdascii_emit.sv
rtl/binary_to_decimal_ascii.sv
test/binary_to_decimal_ascii_tb.sv
